// File: hw/rtl/ils_pkg.sv
package ils_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    CMD_READ = 3'd0,
    CMD_HEAD = 3'd1,
    CMD_TAIL = 3'd2,
    CMD_AT   = 3'd3,
    CMD_DEL  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [CMP_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } shift_ctl_t;

endpackage

// File: hw/rtl/ils_cell.sv
module ils_cell
  import ils_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  shift_ctl_t        ctl,
  input  logic [DATA_W-1:0] from_left,
  input  logic [DATA_W-1:0] from_right,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_part
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [CMP_W-1:0]  my_pos;

  assign my_pos = CMP_W'(idx);

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (my_pos > ctl.pos) begin
        data_nxt = from_left;
      end else if (my_pos == ctl.pos) begin
        data_nxt = ctl.value;
      end
    end else if (ctl.del) begin
      if (my_pos >= ctl.pos) begin
        data_nxt = from_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  // only the addressed cell contributes to the read
  assign rd_part = (my_pos == ctl.pos) ? data_r : '0;

endmodule

// File: hw/rtl/indexed_list_store.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells,
// one entry per cell. Each item carries one command (read, insert at head,
// insert at tail, insert before a position, delete at a position) and yields
// exactly one result with read data and a status. Inserts shift every cell
// after the position and deletes every cell from it on; a read selects the
// addressed cell combinationally, so one item is taken per cycle with its
// result in the next cycle; the only stall comes from a held result register.
// Entries at or above the current count hold stale data, never returned.
module indexed_list_store
  import ils_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_cmd,
  input  logic [POS_W-1:0]  in_position,
  input  logic [DATA_W-1:0] in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] out_read_data,
  output logic [1:0]        out_status
);

  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] out_read_data_r;
  logic [DATA_W-1:0] out_read_data_nxt;
  status_t           out_status_r;
  status_t           out_status_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  logic              in_fire;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              full;
  logic              ins_ok;
  logic              del_ok;
  logic              rd_hit;
  shift_ctl_t        ctl;
  logic [DATA_W-1:0] rd_sel;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign pos_ext  = CMP_W'(in_position);
  assign cnt_ext  = CMP_W'(count_r);
  assign full     = (count_r == CNT_W'(CAPACITY));

  // command decode: effective position, range and full checks
  always_comb begin
    ctl       = '0;
    ctl.value = in_value;
    ctl.pos   = pos_ext;
    ins_ok    = 1'b0;
    del_ok    = 1'b0;
    rd_hit    = 1'b0;
    out_read_data_nxt = '0;
    out_status_nxt    = ST_DONE;
    case (cmd_t'(in_cmd))
      CMD_READ: begin
        if (pos_ext < cnt_ext) begin
          rd_hit = 1'b1;
        end else begin
          out_read_data_nxt = '1;
          out_status_nxt    = ST_RANGE;
        end
      end
      CMD_HEAD: begin
        ctl.pos = '0;
        if (full) out_status_nxt = ST_FULL;
        else ins_ok = 1'b1;
      end
      CMD_TAIL: begin
        ctl.pos = cnt_ext;
        if (full) out_status_nxt = ST_FULL;
        else ins_ok = 1'b1;
      end
      CMD_AT: begin
        // range check wins over full
        if (pos_ext > cnt_ext) out_status_nxt = ST_RANGE;
        else if (full) out_status_nxt = ST_FULL;
        else ins_ok = 1'b1;
      end
      CMD_DEL: begin
        if (pos_ext >= cnt_ext) out_status_nxt = ST_RANGE;
        else del_ok = 1'b1;
      end
      default: begin
      end
    endcase
    ctl.ins = in_fire && ins_ok;
    ctl.del = in_fire && del_ok;
  end

  always_comb begin
    rd_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_sel = rd_sel | cell_rd[i];
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_data[i+1];
    end
    ils_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(i)),
      .ctl        (ctl),
      .from_left  (left_d),
      .from_right (right_d),
      .data       (cell_data[i]),
      .rd_part    (cell_rd[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) count_nxt = count_r + CNT_W'(1);
    else if (ctl.del) count_nxt = count_r - CNT_W'(1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_read_data_r <= rd_hit ? rd_sel : out_read_data_nxt;
      out_status_r    <= out_status_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not grow the list");

  a_del_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.del |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("delete did not shrink the list");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted item produced no result");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && full) |-> !ctl.ins)
    else $error("insert into a full list");

endmodule
